// ===== hdl/touch_baseline_debouncer_top_macros.svh =====
// Assertion macros for the touch baseline debouncer.
`ifndef TOUCH_BASELINE_DEBOUNCER_TOP_MACROS_SVH
`define TOUCH_BASELINE_DEBOUNCER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define TBD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("touch debouncer check failed");

// Next-cycle implication, checked outside reset.
`define TBD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("touch debouncer check failed");

`else

`define TBD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TBD_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/tbd_pkg.sv =====
// Shared types, register codes and constants of the touch baseline debouncer.
package tbd_pkg;

  localparam int unsigned ChanW     = 3;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned BaseW     = 22;
  localparam int unsigned ThrW      = 15;
  localparam int unsigned CountW    = 5;
  localparam int unsigned MaskW     = 6;
  localparam int unsigned CfgDataW  = 15;

  localparam logic [BaseW:0]    StepUp       = 23'd64;
  localparam logic [ThrW-1:0]   NarrowThrRst = 15'd320;
  localparam logic [ThrW-1:0]   WideThrRst   = 15'd640;
  localparam logic [MaskW-1:0]  WideMaskRst  = 6'd28;
  localparam logic [CountW-1:0] LimitRst     = 5'd25;
  localparam logic [CountW-1:0] OnLevelRst   = 5'd15;
  localparam logic [CountW-1:0] OffLevelRst  = 5'd10;

  // Configuration register indexes
  typedef enum logic [ChanW-1:0] {
    REG_NARROW_THR = 3'd0,
    REG_WIDE_THR   = 3'd1,
    REG_WIDE_MASK  = 3'd2,
    REG_LIMIT      = 3'd3,
    REG_ON_LEVEL   = 3'd4,
    REG_OFF_LEVEL  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [ThrW-1:0]   narrow_thr;
    logic [ThrW-1:0]   wide_thr;
    logic [MaskW-1:0]  wide_mask;
    logic [CountW-1:0] limit;
    logic [CountW-1:0] on_level;
    logic [CountW-1:0] off_level;
  } cfg_t;

  typedef struct packed {
    logic [BaseW-1:0]  baseline;
    logic [CountW-1:0] count;
    logic              touched;
    logic              needs_load;
  } chan_state_t;

endpackage

// ===== hdl/tbd_cfg_regs.sv =====
// Configuration register file of the touch baseline debouncer.
module tbd_cfg_regs
  import tbd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [ChanW-1:0]    addr_i,
  input  logic [CfgDataW-1:0] wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Decode the write; unknown indexes leave everything as is
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (reg_idx_e'(addr_i))
        REG_NARROW_THR: cfg_d.narrow_thr = wdata_i[ThrW-1:0];
        REG_WIDE_THR:   cfg_d.wide_thr   = wdata_i[ThrW-1:0];
        REG_WIDE_MASK:  cfg_d.wide_mask  = wdata_i[MaskW-1:0];
        REG_LIMIT:      cfg_d.limit      = wdata_i[CountW-1:0];
        REG_ON_LEVEL:   cfg_d.on_level   = wdata_i[CountW-1:0];
        REG_OFF_LEVEL:  cfg_d.off_level  = wdata_i[CountW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  // Hold registers, load defaults on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.narrow_thr <= NarrowThrRst;
      cfg_q.wide_thr   <= WideThrRst;
      cfg_q.wide_mask  <= WideMaskRst;
      cfg_q.limit      <= LimitRst;
      cfg_q.on_level   <= OnLevelRst;
      cfg_q.off_level  <= OffLevelRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/tbd_chan_update.sv =====
// Per-sample update of one channel: baseline tracking, touch counter, hysteresis.
module tbd_chan_update
  import tbd_pkg::*;
(
  input  logic [ChanW-1:0]   chan_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic               rearm_i,
  input  cfg_t               cfg_i,
  input  chan_state_t        cur_i,
  output chan_state_t        nxt_o
);

  logic [BaseW-1:0]  value;
  logic [BaseW-1:0]  load_val;
  logic [BaseW-1:0]  base0;
  logic [BaseW:0]    up_lim;
  logic [BaseW-1:0]  up_val;
  logic [BaseW-1:0]  down_val;
  logic [BaseW-1:0]  new_base;
  logic [7:0]        mask_ext;
  logic              wide_sel;
  logic [ThrW-1:0]   thr;
  logic              hit;
  logic [CountW:0]   inc;
  logic [CountW-1:0] cnt_n;
  logic              flag_n;

  // Scale the sample by 64; three quarters of that is sample times 48
  assign value    = {sample_i, 6'b0};
  assign load_val = {1'b0, sample_i, 5'b0} + {2'b0, sample_i, 4'b0};
  assign base0    = (cur_i.needs_load || rearm_i) ? load_val : cur_i.baseline;

  // Rise toward the sample by at most one step, or fall by one
  assign up_lim   = {1'b0, base0} + StepUp;
  assign up_val   = ({1'b0, value} < up_lim) ? value : up_lim[BaseW-1:0];
  assign down_val = base0 - 22'd1;
  assign new_base = ((base0 != '0) && (down_val > up_val)) ? down_val : up_val;

  // Pick the threshold; channels outside the mask width use the narrow one
  assign mask_ext = {2'b0, cfg_i.wide_mask};
  assign wide_sel = (chan_i < ChanW'(MaskW)) && mask_ext[chan_i];
  assign thr      = wide_sel ? cfg_i.wide_thr : cfg_i.narrow_thr;

  // Touch when the sample sits more than thr below the new baseline
  assign hit = (({1'b0, value} + (BaseW+1)'(thr)) < {1'b0, new_base});

  // Saturating counter and on/off hysteresis
  always_comb begin
    inc = {1'b0, cur_i.count} + 6'd1;
    if (hit) begin
      cnt_n = (inc < {1'b0, cfg_i.limit}) ? inc[CountW-1:0] : cfg_i.limit;
    end else begin
      cnt_n = (cur_i.count != '0) ? cur_i.count - 5'd1 : '0;
    end
    flag_n = cur_i.touched;
    if (!cur_i.touched && (cnt_n >= cfg_i.on_level)) begin
      flag_n = 1'b1;
    end else if (cur_i.touched && (cnt_n < cfg_i.off_level)) begin
      flag_n = 1'b0;
    end
  end

  assign nxt_o.baseline   = new_base;
  assign nxt_o.count      = cnt_n;
  assign nxt_o.touched    = flag_n;
  assign nxt_o.needs_load = 1'b0;

endmodule

// ===== hdl/touch_baseline_debouncer_top.sv =====
// Top level of the touch baseline debouncer: input stage, channel state, result stage.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   channel_i, sample_i, rearm_i
//   out      output     out_valid_o / out_ready_i channel_echo_o, touched_o,
//                                                 touch_count_o, baseline_o,
//                                                 touched_mask_o
//   cfg      input      cfg_we_i                  cfg_addr_i, cfg_wdata_i
//
// One item per cycle while the result side is not stalled; a taken item passes
// through the input register, then the single-pass update into the result register.
// Channel state lives in flip-flops read and written in the update stage, so
// items on the same channel may follow back to back.
// Reset clears all channel state and marks every baseline for load; no sweep.
// A stalled result holds; the input stage takes one item behind it and then blocks.
`include "touch_baseline_debouncer_top_macros.svh"

module touch_baseline_debouncer_top
  import tbd_pkg::*;
#(
  parameter int unsigned CHANNELS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ChanW-1:0]    cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ChanW-1:0]    channel_i,
  input  logic [SampleW-1:0]  sample_i,
  input  logic                rearm_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ChanW-1:0]    channel_echo_o,
  output logic                touched_o,
  output logic [CountW-1:0]   touch_count_o,
  output logic [BaseW-1:0]    baseline_o,
  output logic [MaskW-1:0]    touched_mask_o
);

  cfg_t cfg;

  logic               s1_valid_q;
  logic [ChanW-1:0]   s1_chan_q;
  logic [SampleW-1:0] s1_sample_q;
  logic               s1_rearm_q;

  logic               fire;
  logic               in_range;
  chan_state_t        cur_st;
  chan_state_t        nxt_st;
  chan_state_t        st_q [CHANNELS];
  logic [MaskW-1:0]   mask_d;

  logic               out_valid_q;
  logic [ChanW-1:0]   echo_q;
  logic               touched_q;
  logic [CountW-1:0]  count_q;
  logic [BaseW-1:0]   base_q;
  logic [MaskW-1:0]   mask_q;

  tbd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .addr_i  (cfg_addr_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // Advance the update stage when the result register is free or drains
  assign fire       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_chan_q   <= channel_i;
      s1_sample_q <= sample_i;
      s1_rearm_q  <= rearm_i;
    end
  end

  // Select the state of the item's channel
  assign in_range = int'(s1_chan_q) < CHANNELS;

  always_comb begin
    cur_st = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (int'(s1_chan_q) == c) begin
        cur_st = st_q[c];
      end
    end
  end

  tbd_chan_update u_upd (
    .chan_i   (s1_chan_q),
    .sample_i (s1_sample_q),
    .rearm_i  (s1_rearm_q),
    .cfg_i    (cfg),
    .cur_i    (cur_st),
    .nxt_o    (nxt_st)
  );

  // Write back the channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        st_q[c].baseline   <= '0;
        st_q[c].count      <= '0;
        st_q[c].touched    <= 1'b0;
        st_q[c].needs_load <= 1'b1;
      end
    end else if (fire && in_range) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (int'(s1_chan_q) == c) begin
          st_q[c] <= nxt_st;
        end
      end
    end
  end

  // Build the touched mask as it stands after this update
  for (genvar g = 0; g < MaskW; g++) begin : g_mask
    if (g < CHANNELS) begin : g_live
      assign mask_d[g] = (fire && (int'(s1_chan_q) == g)) ? nxt_st.touched
                                                          : st_q[g].touched;
    end else begin : g_dead
      assign mask_d[g] = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      echo_q    <= s1_chan_q;
      touched_q <= in_range ? nxt_st.touched  : 1'b0;
      count_q   <= in_range ? nxt_st.count    : '0;
      base_q    <= in_range ? nxt_st.baseline : '0;
      mask_q    <= mask_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign channel_echo_o = echo_q;
  assign touched_o      = touched_q;
  assign touch_count_o  = count_q;
  assign baseline_o     = base_q;
  assign touched_mask_o = mask_q;

  // A held result with a waiting item blocks the input side
  `TBD_ASSERT_IMP(a_stall_blocks, clk_i, rst_ni,
    out_valid_o && !out_ready_i && s1_valid_q, !in_ready_o)

  // A held result stays valid and keeps its baseline
  `TBD_ASSERT_NXT(a_hold_result, clk_i, rst_ni,
    out_valid_o && !out_ready_i, out_valid_o && $stable(baseline_o))

  // Results for channels without state carry zeros
  `TBD_ASSERT_IMP(a_out_of_range_zero, clk_i, rst_ni,
    out_valid_o && (int'(channel_echo_o) >= CHANNELS),
    !touched_o && (touch_count_o == '0) && (baseline_o == '0))

  // The touched flag agrees with its bit in the mask
  `TBD_ASSERT_IMP(a_flag_in_mask, clk_i, rst_ni,
    out_valid_o && (int'(channel_echo_o) < CHANNELS) && (channel_echo_o < 3'd6),
    touched_o == touched_mask_o[channel_echo_o])

endmodule
